### rtl/scap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scap_pkg
// Shared types and codes for the smart card ATR parser: parse phases, byte
// role codes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package scap_pkg;

    // parameter defaults
    localparam int MAX_LEN_DEF    = 33;
    localparam int MAX_LEVELS_DEF = 7;

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int ROLE_W   = 4;
    localparam int LEVEL_W  = 4;
    localparam int STATUS_W = 3;
    localparam int HIST_W   = 4;
    localparam int MASK_W   = 4;

    // initial character codes
    localparam logic [BYTE_W-1:0] TS_DIRECT  = 8'h3B;
    localparam logic [BYTE_W-1:0] TS_INVERSE = 8'h3F;

    // parse phase
    typedef enum logic [2:0] {
        PH_TS   = 3'd0,
        PH_T0   = 3'd1,
        PH_IF   = 3'd2,
        PH_HIST = 3'd3,
        PH_TCK  = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    // byte role codes
    typedef logic [ROLE_W-1:0] role_t;
    localparam role_t ROLE_TS     = 4'd0;
    localparam role_t ROLE_T0     = 4'd1;
    localparam role_t ROLE_TA     = 4'd2;
    localparam role_t ROLE_TB     = 4'd3;
    localparam role_t ROLE_TC     = 4'd4;
    localparam role_t ROLE_TD     = 4'd5;
    localparam role_t ROLE_HIST   = 4'd6;
    localparam role_t ROLE_TCK    = 4'd7;
    localparam role_t ROLE_EXCESS = 4'd8;

    // status codes
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_TOO_SHORT  = 3'd1;
    localparam status_t ST_TOO_LONG   = 3'd2;
    localparam status_t ST_INVALID_TS = 3'd3;
    localparam status_t ST_TOO_MANY   = 3'd4;
    localparam status_t ST_OVERRUN    = 3'd5;
    localparam status_t ST_UNDERRUN   = 3'd6;
    localparam status_t ST_CHECKSUM   = 3'd7;

endpackage

### rtl/smartcard_atr_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smartcard_atr_parser_core
// ISO 7816-3 answer-to-reset parser: labels each ATR byte with its role and
// reports the ATR status, convention, counts and protocol support on the
// final byte.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one ATR byte per request (s_atr_byte, TS first), with
//   s_last_byte high on the final byte of the ATR.
//   m_ channel: one result per input byte, in order. Role and level are
//   valid on every result; status and summary fields are valid when
//   m_done_res is high and are zero otherwise.
//   A request accepted on s_ is held in the input register, parsed by
//   combinational logic and captured in the result register that drives
//   the m_ ports. Throughput is one byte per cycle unless the receiver
//   stalls; the parse is a single pass of shallow logic between the registers.
//   When the receiver stalls, the result register holds its request and the
//   input register takes one more byte before s_ready drops.
//   After the final byte the parser returns to its reset state and the next
//   byte is taken as the TS of a new ATR.
//   Reset (aresetn low, synchronous) empties both registers and puts the
//   parser in its idle state, waiting for TS.
// ----------------------------------------------------------------------------
module smartcard_atr_parser_core
    import scap_pkg::*;
#(
    parameter int MAX_LEN    = MAX_LEN_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BYTE_W-1:0]   s_atr_byte,
    input  logic                s_last_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ROLE_W-1:0]   m_byte_role,
    output logic [LEVEL_W-1:0]  m_level_index,
    output logic                m_done_res,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_direct_convention,
    output logic                m_has_checksum,
    output logic [LEVEL_W-1:0]  m_level_count,
    output logic [HIST_W-1:0]   m_historical_count,
    output logic                m_t0_supported,
    output logic                m_t1_supported
);

    localparam int CNT_W     = $clog2(MAX_LEN + 2);
    localparam int LEVEL_CAP = (MAX_LEVELS + 1 > 15) ? 15 : MAX_LEVELS + 1;
    localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_LEN + 1);
    localparam logic [CNT_W-1:0]   CNT_LIMIT = CNT_W'(MAX_LEN);
    localparam logic [CNT_W-1:0]   CNT_MIN   = CNT_W'(2);
    localparam logic [LEVEL_W-1:0] LVL_MAX   = LEVEL_W'(MAX_LEVELS);
    localparam logic [LEVEL_W-1:0] LVL_CAP   = LEVEL_W'(LEVEL_CAP);
    localparam logic [LEVEL_W-1:0] LVL_ONE   = LEVEL_W'(1);

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              advance;

    // parser state
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    phase_t             phase_reg, phase_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [HIST_W-1:0]  hist_total_reg, hist_total_next;
    logic [HIST_W-1:0]  hist_left_reg, hist_left_next;
    logic               tck_reg, tck_next;
    logic [BYTE_W-1:0]  xor_reg, xor_next;
    logic               direct_reg, direct_next;
    logic               err_ts_reg, err_ts_next;
    logic               err_lvl_reg, err_lvl_next;
    logic               err_excess_reg, err_excess_next;
    logic               t0_seen_reg, t0_seen_next;
    logic               t1_seen_reg, t1_seen_next;
    logic               td_seen_reg, td_seen_next;

    // result fields before the result register
    role_t              role_c;
    logic [LEVEL_W-1:0] lvl_c;
    status_t            status_c;
    logic               ok_c;

    // result register
    logic                m_valid_reg;
    role_t               role_reg;
    logic [LEVEL_W-1:0]  lvl_reg;
    logic                done_reg;
    status_t             status_reg;
    logic                conv_reg;
    logic                hascs_reg;
    logic [LEVEL_W-1:0]  lcount_reg;
    logic [HIST_W-1:0]   hcount_reg;
    logic                t0_reg;
    logic                t1_reg;

    // handshake: parse when the result register is free or being drained
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_atr_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // next-state parse of the held byte
    always_comb begin
        cnt_next        = (cnt_reg < CNT_MAX) ? cnt_reg + CNT_W'(1) : cnt_reg;
        phase_next      = phase_reg;
        mask_next       = mask_reg;
        level_next      = level_reg;
        hist_total_next = hist_total_reg;
        hist_left_next  = hist_left_reg;
        tck_next        = tck_reg;
        xor_next        = xor_reg;
        direct_next     = direct_reg;
        err_ts_next     = err_ts_reg;
        err_lvl_next    = err_lvl_reg;
        err_excess_next = err_excess_reg;
        t0_seen_next    = t0_seen_reg;
        t1_seen_next    = t1_seen_reg;
        td_seen_next    = td_seen_reg;
        unique case (phase_reg)
            PH_TS: begin
                if (in_byte_reg == TS_DIRECT) begin
                    direct_next = 1'b1;
                end else if (in_byte_reg != TS_INVERSE) begin
                    direct_next = 1'b0;
                    err_ts_next = 1'b1;
                end
                phase_next = PH_T0;
            end
            PH_T0: begin
                xor_next        = xor_reg ^ in_byte_reg;
                hist_total_next = in_byte_reg[3:0];
                hist_left_next  = in_byte_reg[3:0];
                mask_next       = in_byte_reg[7:4];
                if (in_byte_reg[7:4] != '0) begin
                    phase_next = PH_IF;
                end else if (in_byte_reg[3:0] != '0) begin
                    phase_next = PH_HIST;
                end else begin
                    phase_next = tck_reg ? PH_TCK : PH_DONE;
                end
            end
            PH_IF: begin
                xor_next = xor_reg ^ in_byte_reg;
                if (mask_reg[0]) begin
                    mask_next[0] = 1'b0;
                end else if (mask_reg[1]) begin
                    mask_next[1] = 1'b0;
                end else if (mask_reg[2]) begin
                    mask_next[2] = 1'b0;
                end else begin
                    // TD: protocol in low nibble, next level's bytes in high
                    td_seen_next = 1'b1;
                    if (in_byte_reg[3:0] == 4'd0) begin
                        t0_seen_next = 1'b1;
                    end else begin
                        tck_next = 1'b1;
                    end
                    if (in_byte_reg[3:0] == 4'd1) begin
                        t1_seen_next = 1'b1;
                    end
                    mask_next = in_byte_reg[7:4];
                    if (in_byte_reg[7:4] != '0) begin
                        if (level_reg >= LVL_MAX) begin
                            err_lvl_next = 1'b1;
                        end
                        if (level_reg < LVL_CAP) begin
                            level_next = level_reg + LVL_ONE;
                        end
                    end
                end
                if (mask_next == '0) begin
                    if (hist_left_reg != '0) begin
                        phase_next = PH_HIST;
                    end else begin
                        phase_next = tck_next ? PH_TCK : PH_DONE;
                    end
                end
            end
            PH_HIST: begin
                xor_next = xor_reg ^ in_byte_reg;
                if (hist_left_reg != '0) begin
                    hist_left_next = hist_left_reg - HIST_W'(1);
                end
                if (hist_left_next == '0) begin
                    phase_next = tck_reg ? PH_TCK : PH_DONE;
                end
            end
            PH_TCK: begin
                xor_next   = xor_reg ^ in_byte_reg;
                phase_next = PH_DONE;
            end
            default: begin
                xor_next        = xor_reg ^ in_byte_reg;
                err_excess_next = 1'b1;
            end
        endcase
    end

    // role and level of the held byte
    always_comb begin
        lvl_c = '0;
        unique case (phase_reg)
            PH_TS:   role_c = ROLE_TS;
            PH_T0:   role_c = ROLE_T0;
            PH_IF: begin
                lvl_c = level_reg;
                if (mask_reg[0]) begin
                    role_c = ROLE_TA;
                end else if (mask_reg[1]) begin
                    role_c = ROLE_TB;
                end else if (mask_reg[2]) begin
                    role_c = ROLE_TC;
                end else begin
                    role_c = ROLE_TD;
                end
            end
            PH_HIST: role_c = ROLE_HIST;
            PH_TCK:  role_c = ROLE_TCK;
            default: role_c = ROLE_EXCESS;
        endcase
    end

    // final status, in priority order
    always_comb begin
        if (cnt_next < CNT_MIN) begin
            status_c = ST_TOO_SHORT;
        end else if (cnt_next > CNT_LIMIT) begin
            status_c = ST_TOO_LONG;
        end else if (err_ts_next) begin
            status_c = ST_INVALID_TS;
        end else if (err_lvl_next) begin
            status_c = ST_TOO_MANY;
        end else if (phase_next != PH_DONE) begin
            status_c = ST_OVERRUN;
        end else if (err_excess_next) begin
            status_c = ST_UNDERRUN;
        end else if (tck_next && (xor_next != '0)) begin
            status_c = ST_CHECKSUM;
        end else begin
            status_c = ST_OK;
        end
        ok_c = (status_c == ST_OK);
    end

    // parser state registers, back to idle after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_last_reg)) begin
            cnt_reg        <= '0;
            phase_reg      <= PH_TS;
            mask_reg       <= '0;
            level_reg      <= LVL_ONE;
            hist_total_reg <= '0;
            hist_left_reg  <= '0;
            tck_reg        <= 1'b0;
            xor_reg        <= '0;
            direct_reg     <= 1'b0;
            err_ts_reg     <= 1'b0;
            err_lvl_reg    <= 1'b0;
            err_excess_reg <= 1'b0;
            t0_seen_reg    <= 1'b0;
            t1_seen_reg    <= 1'b0;
            td_seen_reg    <= 1'b0;
        end else if (advance) begin
            cnt_reg        <= cnt_next;
            phase_reg      <= phase_next;
            mask_reg       <= mask_next;
            level_reg      <= level_next;
            hist_total_reg <= hist_total_next;
            hist_left_reg  <= hist_left_next;
            tck_reg        <= tck_next;
            xor_reg        <= xor_next;
            direct_reg     <= direct_next;
            err_ts_reg     <= err_ts_next;
            err_lvl_reg    <= err_lvl_next;
            err_excess_reg <= err_excess_next;
            t0_seen_reg    <= t0_seen_next;
            t1_seen_reg    <= t1_seen_next;
            td_seen_reg    <= td_seen_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance) begin
            role_reg   <= role_c;
            lvl_reg    <= lvl_c;
            done_reg   <= in_last_reg;
            status_reg <= in_last_reg ? status_c : ST_OK;
            conv_reg   <= in_last_reg && direct_next;
            hascs_reg  <= in_last_reg && ok_c && tck_next;
            lcount_reg <= in_last_reg ? level_next : '0;
            hcount_reg <= in_last_reg ? hist_total_next : '0;
            t0_reg     <= in_last_reg && ok_c && (!td_seen_next || t0_seen_next);
            t1_reg     <= in_last_reg && ok_c && t1_seen_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_byte_role         = role_reg;
    assign m_level_index       = lvl_reg;
    assign m_done_res          = done_reg;
    assign m_status            = status_reg;
    assign m_direct_convention = conv_reg;
    assign m_has_checksum      = hascs_reg;
    assign m_level_count       = lcount_reg;
    assign m_historical_count  = hcount_reg;
    assign m_t0_supported      = t0_reg;
    assign m_t1_supported      = t1_reg;

`ifndef SYNTH
    // summary status only on the final result
    a_status_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_done_res) |-> (m_status == ST_OK))
        else $error("status set on a non-final result");

    // level index only on interface bytes
    a_level_only_if: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_level_index != '0)) |->
        ((m_byte_role == ROLE_TA) || (m_byte_role == ROLE_TB) ||
         (m_byte_role == ROLE_TC) || (m_byte_role == ROLE_TD)))
        else $error("level index on a non-interface byte");

    // protocol support requires a good ATR
    a_proto_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_t1_supported || m_has_checksum)) |->
        (m_done_res && (m_status == ST_OK)))
        else $error("protocol flags on a failed ATR");

    // final byte returns the parser to TS
    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (phase_reg == PH_TS) && (cnt_reg == '0))
        else $error("parser not idle after final byte");
`endif

endmodule
